>>> hw/rtl/joystick_servo_jog_controller_core_macros.svh
// Assertion macros shared by the jog controller RTL.
// Included by the top level; depends on nothing else.
`ifndef JOYSTICK_SERVO_JOG_CONTROLLER_CORE_MACROS_SVH
`define JOYSTICK_SERVO_JOG_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JSJC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSJC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/jsjc_pkg.sv
// Shared types and constants for the joystick servo jog controller.
// Used by jsjc_jog, jsjc_scale and the top level; no dependencies.
package jsjc_pkg;

	localparam int ADC_W    = 12;
	localparam int ADC_BITS = 12;
	localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((1 << ADC_BITS) - 1);

	localparam int DUTY_W   = 10;
	localparam int PERIOD_W = 16;
	localparam int PROD_W   = PERIOD_W + DUTY_W;
	localparam int CMP_W    = 16;
	localparam int JOINTS   = 6;

	localparam logic [ADC_W-1:0] HIGH_A = ADC_W'(3000);
	localparam logic [ADC_W-1:0] HIGH_B = ADC_W'(3500);
	localparam logic [ADC_W-1:0] LOW_TH = ADC_W'(1500);

	localparam logic [DUTY_W-1:0] DUTY_RESET = DUTY_W'(75);

	// floor(p / 1000) = (p * ceil(2^36 / 1000)) >> 36, exact for p below 2^26.
	localparam int RECIP_W   = 27;
	localparam int DIV_SHIFT = 36;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(68719477);
	localparam int QUOT_W    = PROD_W + RECIP_W - DIV_SHIFT;

	localparam int J_BASE     = 0;
	localparam int J_SHOULDER = 1;
	localparam int J_ELBOW    = 2;
	localparam int J_WRIST    = 3;
	localparam int J_HAND     = 4;
	localparam int J_GRIPPER  = 5;

	typedef enum logic [2:0] {
		REG_MAX_BASE     = 3'd0,
		REG_MAX_SHOULDER = 3'd1,
		REG_MAX_ELBOW    = 3'd2,
		REG_MAX_WRIST    = 3'd3,
		REG_MAX_HAND     = 3'd4,
		REG_MAX_GRIPPER  = 3'd5,
		REG_MIN_DUTY     = 3'd6,
		REG_SERVO_PERIOD = 3'd7
	} reg_index_t;

	typedef logic [JOINTS-1:0][DUTY_W-1:0] duty_vec_t;

	typedef struct packed {
		logic [ADC_W-1:0] stick1_x;
		logic [ADC_W-1:0] stick1_y;
		logic [ADC_W-1:0] stick2_x;
		logic [ADC_W-1:0] stick2_y;
		logic             button_level;
	} jsjc_in_t;

	typedef struct packed {
		logic [CMP_W-1:0] base_compare;
		logic [CMP_W-1:0] elbow_compare;
		logic [CMP_W-1:0] shoulder_compare;
		logic [CMP_W-1:0] hand_compare;
		logic [CMP_W-1:0] wrist_compare;
		logic [CMP_W-1:0] gripper_compare;
		logic             arm_mode;
	} jsjc_out_t;

	typedef struct packed {
		duty_vec_t         max_duty;
		logic [DUTY_W-1:0] min_duty;
	} jsjc_limits_t;

	typedef struct packed {
		logic      mode;
		logic      button_prev;
		duty_vec_t duty;
	} jsjc_state_t;

endpackage

>>> hw/rtl/jsjc_jog.sv
// Next-state logic for one control tick: mode toggle and joint jogging.
// Depends on jsjc_pkg.
module jsjc_jog import jsjc_pkg::*; (
	input  jsjc_in_t     item,
	input  jsjc_state_t  cur,
	input  jsjc_limits_t limits,
	output jsjc_state_t  nxt
);

	logic [ADC_W-1:0]  x1, y1, x2, y2;
	logic              arm;
	logic [JOINTS-1:0] up, dn;

	always_comb begin
		x1 = item.stick1_x & ADC_MASK;
		y1 = item.stick1_y & ADC_MASK;
		x2 = item.stick2_x & ADC_MASK;
		y2 = item.stick2_y & ADC_MASK;

		// Only a press after a released level flips the mode.
		arm = cur.mode ^ (cur.button_prev & ~item.button_level);

		up = '0;
		dn = '0;
		up[J_BASE]     = arm && (x1 > HIGH_A);
		dn[J_BASE]     = arm && (x1 < LOW_TH);
		up[J_SHOULDER] = arm && (y1 < LOW_TH);
		dn[J_SHOULDER] = arm && (y1 > HIGH_A);
		up[J_ELBOW]    = arm && (x2 > HIGH_B);
		dn[J_ELBOW]    = arm && (x2 < LOW_TH);
		up[J_HAND]     = arm && (y2 < LOW_TH);
		dn[J_HAND]     = arm && (y2 > HIGH_B);
		up[J_GRIPPER]  = !arm && (x2 > HIGH_B);
		dn[J_GRIPPER]  = !arm && (x2 < LOW_TH);
		up[J_WRIST]    = !arm && (y2 < LOW_TH);
		dn[J_WRIST]    = !arm && (y2 > HIGH_B);

		nxt.mode        = arm;
		nxt.button_prev = item.button_level;
		for (int j = 0; j < JOINTS; j++) begin
			if (up[j] && (cur.duty[j] < limits.max_duty[j])) begin
				nxt.duty[j] = cur.duty[j] + DUTY_W'(1);
			end else if (dn[j] && (cur.duty[j] > limits.min_duty)) begin
				nxt.duty[j] = cur.duty[j] - DUTY_W'(1);
			end else begin
				nxt.duty[j] = cur.duty[j];
			end
		end
	end

endmodule

>>> hw/rtl/jsjc_scale.sv
// Duty to PWM compare conversion: period times duty, divided by 1000, saturated.
// Two pipeline stages; depends on jsjc_pkg.
module jsjc_scale import jsjc_pkg::*; (
	input  logic                clk,
	input  logic                load_s3,
	input  logic                load_s4,
	input  logic [PERIOD_W-1:0] period,
	input  logic [DUTY_W-1:0]   duty,
	output logic [CMP_W-1:0]    compare
);

	logic [PROD_W-1:0]                prod_s3;
	logic [PROD_W+RECIP_W-1:0]        scaled;
	logic [QUOT_W-1:0]                quot;
	logic [CMP_W-1:0]                 compare_s4;

	assign scaled  = PROD_W'(prod_s3) * RECIP;
	assign quot    = scaled[PROD_W+RECIP_W-1:DIV_SHIFT];
	assign compare = compare_s4;

	always_ff @(posedge clk) begin
		if (load_s3) begin
			prod_s3 <= PROD_W'(period) * PROD_W'(duty);
		end
		if (load_s4) begin
			compare_s4 <= (quot > QUOT_W'({CMP_W{1'b1}})) ? {CMP_W{1'b1}} : quot[CMP_W-1:0];
		end
	end

endmodule

>>> hw/rtl/joystick_servo_jog_controller_core.sv
// Joystick servo jog controller, top level.
// An accepted item passes the input register, then the state update, multiply and divide-by-1000
// registers before out_valid rises. Throughput: one item per cycle while out_stall is low, with
// the four-stage pipeline advancing whenever the stage ahead moves or is empty.
// Reset: mode is arm, button released, all duties 75, limits and period at defaults.
`include "joystick_servo_jog_controller_core_macros.svh"
module joystick_servo_jog_controller_core import jsjc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  jsjc_in_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output jsjc_out_t           out_data,
	input  logic                wr_en,
	input  reg_index_t          wr_index,
	input  logic [PERIOD_W-1:0] wr_data
);

	jsjc_limits_t        limits_q;
	logic [PERIOD_W-1:0] period_q;
	jsjc_state_t         state_q;
	jsjc_state_t         state_nxt;

	logic      vld_s1, vld_s2, vld_s3, vld_s4;
	logic      load_s1, load_s2, load_s3, load_s4;
	jsjc_in_t  item_s1;
	duty_vec_t duty_s2;
	logic      mode_s2, mode_s3, mode_s4;
	logic [JOINTS-1:0][CMP_W-1:0] cmp;

	assign load_s4  = !vld_s4 || !out_stall;
	assign load_s3  = !vld_s3 || load_s4;
	assign load_s2  = !vld_s2 || load_s3;
	assign load_s1  = !vld_s1 || load_s2;
	assign in_stall = !load_s1;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.max_duty[J_BASE]     <= DUTY_W'(130);
			limits_q.max_duty[J_SHOULDER] <= DUTY_W'(110);
			limits_q.max_duty[J_ELBOW]    <= DUTY_W'(127);
			limits_q.max_duty[J_WRIST]    <= DUTY_W'(125);
			limits_q.max_duty[J_HAND]     <= DUTY_W'(128);
			limits_q.max_duty[J_GRIPPER]  <= DUTY_W'(73);
			limits_q.min_duty             <= DUTY_W'(40);
			period_q                      <= PERIOD_W'(20000);
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_BASE:     limits_q.max_duty[J_BASE]     <= wr_data[DUTY_W-1:0];
				REG_MAX_SHOULDER: limits_q.max_duty[J_SHOULDER] <= wr_data[DUTY_W-1:0];
				REG_MAX_ELBOW:    limits_q.max_duty[J_ELBOW]    <= wr_data[DUTY_W-1:0];
				REG_MAX_WRIST:    limits_q.max_duty[J_WRIST]    <= wr_data[DUTY_W-1:0];
				REG_MAX_HAND:     limits_q.max_duty[J_HAND]     <= wr_data[DUTY_W-1:0];
				REG_MAX_GRIPPER:  limits_q.max_duty[J_GRIPPER]  <= wr_data[DUTY_W-1:0];
				REG_MIN_DUTY:     limits_q.min_duty             <= wr_data[DUTY_W-1:0];
				REG_SERVO_PERIOD: period_q                      <= wr_data;
				default: ;
			endcase
		end
	end

	jsjc_jog u_jog (
		.item   (item_s1),
		.cur    (state_q),
		.limits (limits_q),
		.nxt    (state_nxt)
	);

	// Pipeline control and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1            <= 1'b0;
			vld_s2            <= 1'b0;
			vld_s3            <= 1'b0;
			vld_s4            <= 1'b0;
			state_q.mode        <= 1'b1;
			state_q.button_prev <= 1'b1;
			state_q.duty        <= {JOINTS{DUTY_RESET}};
		end else begin
			if (load_s1) vld_s1 <= in_valid;
			if (load_s2) vld_s2 <= vld_s1;
			if (load_s3) vld_s3 <= vld_s2;
			if (load_s4) vld_s4 <= vld_s3;
			if (vld_s1 && load_s2) begin
				state_q <= state_nxt;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_s1) item_s1 <= in_data;
		if (load_s2) begin
			duty_s2 <= state_nxt.duty;
			mode_s2 <= state_nxt.mode;
		end
		if (load_s3) mode_s3 <= mode_s2;
		if (load_s4) mode_s4 <= mode_s3;
	end

	for (genvar j = 0; j < JOINTS; j++) begin : g_scale
		jsjc_scale u_scale (
			.clk     (clk),
			.load_s3 (load_s3),
			.load_s4 (load_s4),
			.period  (period_q),
			.duty    (duty_s2[j]),
			.compare (cmp[j])
		);
	end

	assign out_valid                 = vld_s4;
	assign out_data.base_compare     = cmp[J_BASE];
	assign out_data.elbow_compare    = cmp[J_ELBOW];
	assign out_data.shoulder_compare = cmp[J_SHOULDER];
	assign out_data.hand_compare     = cmp[J_HAND];
	assign out_data.wrist_compare    = cmp[J_WRIST];
	assign out_data.gripper_compare  = cmp[J_GRIPPER];
	assign out_data.arm_mode         = mode_s4;

	// The input is held off only when every stage holds an item.
	`JSJC_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall, vld_s1 && vld_s2 && vld_s3 && vld_s4, "input stalled with a pipeline bubble")
	// Mode changes only on a press that follows a released level.
	`JSJC_ASSERT_NEXT(a_mode_edge, clk, arst_n, !(vld_s1 && load_s2 && state_q.button_prev && !item_s1.button_level), $stable(state_q.mode), "mode changed without a button press")
	// Joint duties move only when an item passes the update stage.
	`JSJC_ASSERT_NEXT(a_duty_hold, clk, arst_n, !(vld_s1 && load_s2), $stable(state_q.duty), "duty changed without an item")

endmodule
